// File: design/ptq_pkg.sv
package ptq_pkg;

  // Timer bank geometry.
  localparam int NUM_TIMERS = 16;
  localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  // Field widths.
  localparam int ID_W   = 4;
  localparam int MS_W   = 32;
  localparam int NS_W   = 64;
  localparam int CONV_W = 20;
  localparam int PROD_W = MS_W + CONV_W;

  // Stream packing.
  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 8;

  // Milliseconds to nanoseconds.
  localparam logic [CONV_W-1:0] NS_PER_MS = CONV_W'(1000000);

  // Input item kinds carried on the slave-side tuser.
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // take the input item
    logic mul_en;      // load the product register
    logic mul_period;  // multiply the selected timer's period instead of the delay
    logic arm_wr;      // write deadline, period and armed for a start item
    logic scan_clear;  // restart the selection scan
    logic scan_step;   // examine one timer
    logic first_done;  // the first scan of a tick has built the due set
    logic fire_upd;    // take the selected timer out of the due set
    logic rearm_wr;    // rearm or disarm the selected timer
    logic out_load;    // load the result register
    logic out_fire;    // the loaded result reports a fired timer
  } ptq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_tick;     // the offered input item is a tick
    logic idx_last;    // the scan is at the last timer
    logic best_valid;  // the scan has found a due timer
    logic out_taken;   // the pending result transfer completes
  } ptq_sts_t;

endpackage

// File: design/periodic_timer_queue.sv
// Bank of NUM_TIMERS timers kept by absolute deadline in nanoseconds. A start transfer
// (tuser 0) arms a timer at now_ns + delay_ms * 1e6 and returns one closing result. A
// tick transfer (tuser 1) returns one result per armed timer whose deadline lies strictly
// before now_ns, in deadline order with ties to the lower id, then a closing result
// with tlast set. Items are taken one at a time. A start passes through S_MUL and S_ARM, then
// waits for its result transfer. A tick waits for each of its result transfers, and every
// selection is a full scan of the timer storage through one deadline comparator, one timer
// per cycle.
module periodic_timer_queue
  import ptq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // timer_id[3:0], delay_ms[35:4], reload_ms[67:36], now_ns[131:68], zero fill
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // mode: 0 start, 1 tick
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // expired_id[3:0], zero fill
  output logic [OUT_DATA_W-1:0] m_tdata,
  // fired
  output logic                  m_tuser,
  output logic                  m_tlast
);

  ptq_cmd_t cmd;
  ptq_sts_t sts;

  ptq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ptq_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// File: design/ptq_datapath.sv
module ptq_datapath
  import ptq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  ptq_cmd_t              cmd,
  output ptq_sts_t              sts,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tuser,
  output logic                  m_tlast
);

  // Captured input item.
  logic [ID_W-1:0] timer_id;
  logic [MS_W-1:0] delay_ms;
  logic [MS_W-1:0] reload_ms;
  logic [NS_W-1:0] now_ns;

  // Timer storage.
  logic [NS_W-1:0]       deadline [NUM_TIMERS];
  logic [MS_W-1:0]       period   [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] armed;
  logic [NUM_TIMERS-1:0] due;

  // Scan and selection.
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] best;
  logic [NS_W-1:0]  best_dl;
  logic             best_valid;
  logic             first;

  // Arithmetic.
  logic [PROD_W-1:0] prod;
  logic [MS_W-1:0]   mul_src;
  logic [PROD_W-1:0] mul_res;
  logic [NS_W-1:0]   new_dl;

  // Result register.
  logic [ID_W-1:0] out_id;
  logic            out_fired;
  logic            out_last;

  logic [NS_W-1:0]  dl_rd;
  logic [MS_W-1:0]  per_rd;
  logic             cand;
  logic             in_range;
  logic [IDX_W-1:0] id_idx;

  assign id_idx   = IDX_W'(timer_id);
  assign in_range = int'(timer_id) < NUM_TIMERS;
  assign dl_rd    = deadline[idx];
  assign per_rd   = period[best];

  // A timer is a candidate if it was due when the tick began and has not fired yet.
  assign cand = first ? (armed[idx] && (dl_rd < now_ns)) : due[idx];

  assign mul_src = cmd.mul_period ? per_rd : delay_ms;
  assign mul_res = PROD_W'(mul_src) * PROD_W'(NS_PER_MS);
  assign new_dl  = now_ns + NS_W'(prod);

  // Input capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      timer_id  <= s_tdata[ID_W-1:0];
      delay_ms  <= s_tdata[ID_W+MS_W-1:ID_W];
      reload_ms <= s_tdata[ID_W+2*MS_W-1:ID_W+MS_W];
      now_ns    <= s_tdata[ID_W+2*MS_W+NS_W-1:ID_W+2*MS_W];
    end
  end

  // Product register between the multiplier and the deadline adder.
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= mul_res;
    end
  end

  // Deadline and period storage.
  always_ff @(posedge clk) begin
    if (cmd.arm_wr && in_range) begin
      deadline[id_idx] <= new_dl;
      period[id_idx]   <= reload_ms;
    end else if (cmd.rearm_wr && (per_rd != '0)) begin
      deadline[best] <= new_dl;
    end
  end

  // Armed flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= '0;
    end else if (cmd.arm_wr && in_range) begin
      armed[id_idx] <= 1'b1;
    end else if (cmd.rearm_wr && (per_rd == '0)) begin
      armed[best] <= 1'b0;
    end
  end

  // Due set: built on the first pass of a tick, trimmed as timers fire.
  always_ff @(posedge clk) begin
    if (cmd.scan_step && first) begin
      due[idx] <= cand;
    end else if (cmd.fire_upd) begin
      due[best] <= 1'b0;
    end
  end

  // First-pass flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      first <= 1'b0;
    end else if (cmd.capture) begin
      first <= 1'b1;
    end else if (cmd.first_done) begin
      first <= 1'b0;
    end
  end

  // Scan counter and running minimum; strict compare keeps the lower id on ties.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      best_valid <= 1'b0;
    end else if (cmd.scan_clear) begin
      idx        <= '0;
      best_valid <= 1'b0;
    end else if (cmd.scan_step) begin
      idx <= IDX_W'(idx + 1'b1);
      if (cand && (!best_valid || (dl_rd < best_dl))) begin
        best_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && cand && (!best_valid || (dl_rd < best_dl))) begin
      best    <= idx;
      best_dl <= dl_rd;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_id    <= cmd.out_fire ? ID_W'(best) : '0;
      out_fired <= cmd.out_fire;
      out_last  <= !cmd.out_fire;
    end
  end

  assign m_tdata = {(OUT_DATA_W-ID_W)'(0), out_id};
  assign m_tuser = out_fired;
  assign m_tlast = out_last;

  // Status.
  assign sts.in_tick    = (s_tuser == MODE_TICK);
  assign sts.idx_last   = (idx == IDX_W'(NUM_TIMERS - 1));
  assign sts.best_valid = best_valid;
  assign sts.out_taken  = m_tvalid && m_tready;

endmodule

// File: design/ptq_ctrl.sv
module ptq_ctrl
  import ptq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  ptq_sts_t sts,
  output ptq_cmd_t cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_MUL       = 4'd1;
  localparam logic [3:0] S_ARM       = 4'd2;
  localparam logic [3:0] S_SCAN      = 4'd3;
  localparam logic [3:0] S_DECIDE    = 4'd4;
  localparam logic [3:0] S_FIRE_MUL  = 4'd5;
  localparam logic [3:0] S_FIRE_WR   = 4'd6;
  localparam logic [3:0] S_WAIT_FIRE = 4'd7;
  localparam logic [3:0] S_WAIT_LAST = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture    = 1'b1;
          cmd.scan_clear = 1'b1;
          state_next     = sts.in_tick ? S_SCAN : S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = S_ARM;
      end
      S_ARM: begin
        cmd.arm_wr   = 1'b1;
        cmd.out_load = 1'b1;
        state_next   = S_WAIT_LAST;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.idx_last) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.first_done = 1'b1;
        if (sts.best_valid) begin
          state_next = S_FIRE_MUL;
        end else begin
          cmd.out_load = 1'b1;
          state_next   = S_WAIT_LAST;
        end
      end
      S_FIRE_MUL: begin
        cmd.mul_en     = 1'b1;
        cmd.mul_period = 1'b1;
        cmd.fire_upd   = 1'b1;
        state_next     = S_FIRE_WR;
      end
      // The fired result is loaded here so that its transfer is seen in S_WAIT_FIRE.
      S_FIRE_WR: begin
        cmd.rearm_wr = 1'b1;
        cmd.out_load = 1'b1;
        cmd.out_fire = 1'b1;
        state_next   = S_WAIT_FIRE;
      end
      S_WAIT_FIRE: begin
        if (sts.out_taken) begin
          cmd.scan_clear = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_WAIT_LAST: begin
        if (sts.out_taken) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: design/ptq_checker.sv
module ptq_checker
  import ptq_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tuser,
  input logic                  m_tlast
);

  // A stalled result holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result changed while stalled");

  // No new item is taken while a result is pending.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while a result is pending");

  // Every result that does not close an item reports a fired timer.
  a_mid_fired: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tuser)
    else $error("non-final result without fired");

  // A result that reports no timer is the closing one and carries id zero.
  a_close_form: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast && (m_tdata == '0))
    else $error("malformed closing result");

  // After the closing transfer the block is ready for the next item.
  a_ready_after: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> s_tready)
    else $error("not ready after closing transfer");

endmodule

bind periodic_timer_queue ptq_checker u_ptq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// File: sim/timer_expiry_checker.sv
module timer_expiry_checker
  import ptq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  // timer_id[3:0], delay_ms[35:4], reload_ms[67:36], now_ns[131:68], zero fill
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // mode: 0 start, 1 tick
  input  logic                  s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  // expired_id[3:0], zero fill
  input  logic [OUT_DATA_W-1:0] m_tdata,
  // fired
  input  logic                  m_tuser,
  input  logic                  m_tlast,
  output int                    fail_count,
  output int                    pending,
  output int                    start_count,
  output int                    tick_count,
  output int                    expiry_count
);

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            fired;
    logic            last;
  } expiry_t;

  localparam logic [NS_W-1:0] NS_PER_MS_64 = 64'd1000000;

  // Shadow copy of the timer bank.
  logic [NS_W-1:0]       shadow_deadline [NUM_TIMERS];
  logic [MS_W-1:0]       shadow_period [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] shadow_armed = '0;

  // Results still owed by the block, oldest first.
  expiry_t expiry_q[$];

  int fails    = 0;
  int starts   = 0;
  int ticks    = 0;
  int expiries = 0;

  // Updates the shadow bank for one item and queues the results it owes.
  task automatic predict_expiries(input logic mode, input logic [ID_W-1:0] id,
                                  input logic [MS_W-1:0] delay_ms,
                                  input logic [MS_W-1:0] reload_ms,
                                  input logic [NS_W-1:0] now_ns);
    logic [NUM_TIMERS-1:0] due;
    int best;
    if (mode == MODE_START) begin
      // Arming an armed timer simply overwrites its deadline and period.
      shadow_deadline[id] = now_ns + {32'd0, delay_ms} * NS_PER_MS_64;
      shadow_period[id]   = reload_ms;
      shadow_armed[id]    = 1'b1;
    end else begin
      // The due set is frozen here, so a rearm that wraps cannot fire twice.
      for (int i = 0; i < NUM_TIMERS; i++) begin
        due[i] = shadow_armed[i] && (shadow_deadline[i] < now_ns);
      end
      while (due != '0) begin
        best = -1;
        // Strict compare keeps the lower id on equal deadlines.
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (due[i] && (best < 0 || shadow_deadline[i] < shadow_deadline[best])) begin
            best = i;
          end
        end
        due[best] = 1'b0;
        expiry_q.push_back('{id: ID_W'(best), fired: 1'b1, last: 1'b0});
        if (shadow_period[best] != '0) begin
          shadow_deadline[best] = now_ns + {32'd0, shadow_period[best]} * NS_PER_MS_64;
        end else begin
          shadow_armed[best] = 1'b0;
        end
      end
    end
    // Every item ends with one closing result.
    expiry_q.push_back('{id: '0, fired: 1'b0, last: 1'b1});
  endtask

  // Watch both channels; inputs first so same-edge ordering cannot matter.
  always @(posedge clk) begin
    expiry_t got;
    expiry_t want;
    if (rst) begin
      expiry_q.delete();
      shadow_armed = '0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (s_tuser == MODE_TICK) begin
          ticks++;
        end else begin
          starts++;
        end
        predict_expiries(s_tuser, s_tdata[3:0], s_tdata[35:4], s_tdata[67:36],
                         s_tdata[131:68]);
      end
      if (m_tvalid && m_tready) begin
        got = '{id: m_tdata[ID_W-1:0], fired: m_tuser, last: m_tlast};
        if (expiry_q.size() == 0) begin
          $error("unexpected result transfer: expired_id %0d fired %0b last %0b",
                 got.id, got.fired, got.last);
          fails++;
        end else begin
          want = expiry_q.pop_front();
          if (got.id != want.id) begin
            $error("expired_id: expected %0d, got %0d", want.id, got.id);
            fails++;
          end
          if (got.fired != want.fired) begin
            $error("fired: expected %0b, got %0b", want.fired, got.fired);
            fails++;
          end
          if (got.last != want.last) begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            fails++;
          end
          if (want.fired) begin
            expiries++;
          end
        end
      end
    end
    fail_count   <= fails;
    pending      <= expiry_q.size();
    start_count  <= starts;
    tick_count   <= ticks;
    expiry_count <= expiries;
  end

endmodule

// File: sim/testbench.sv
module testbench;
  import ptq_pkg::*;

  localparam int RAND_ITEMS  = 360;
  localparam int CYCLE_LIMIT = 1000000;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic                  s_tuser  = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;

  int fail_count;
  int pending;
  int start_count;
  int tick_count;
  int expiry_count;

  int          cycles   = 0;
  logic        no_idle  = 1'b0;
  int          rand_items;
  int          n_starts;
  int          n_ticks;
  logic [63:0] wall_ns;
  logic [31:0] delay_ms;
  logic [31:0] reload_ms;

  periodic_timer_queue u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  timer_expiry_checker u_expiry_chk (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .m_tlast      (m_tlast),
    .fail_count   (fail_count),
    .pending      (pending),
    .start_count  (start_count),
    .tick_count   (tick_count),
    .expiry_count (expiry_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side backpressure.
  always @(posedge clk) begin
    m_tready <= no_idle || ($urandom_range(99) >= 26);
  end

  // Offers one item and holds it until the transfer completes.
  task automatic send_item(input logic mode, input logic [3:0] id,
                           input logic [31:0] dly, input logic [31:0] rpt,
                           input logic [63:0] now);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(99) < 26) begin
      gap = $urandom_range(4, 1);
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {4'd0, now, rpt, dly, id};
    do @(posedge clk); while (!s_tready);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Tick with nothing armed, junk in the fields a tick ignores.
    send_item(MODE_TICK, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd0);
    // All timers share one deadline; odd ones repeat.
    for (int i = 0; i < NUM_TIMERS; i++) begin
      send_item(MODE_START, 4'(i), 32'd1, (i % 2 == 1) ? 32'(i) : 32'd0, 64'd0);
    end
    // A deadline equal to the current time must not fire.
    send_item(MODE_TICK, 4'd0, 32'd0, 32'd0, 64'd1000000);
    // One nanosecond later every timer fires, in id order.
    send_item(MODE_TICK, 4'd0, 32'd0, 32'd0, 64'd1000001);
    // Rearm an armed timer with the longest period.
    send_item(MODE_START, 4'd5, 32'd0, 32'hFFFF_FFFF, 64'd0);
    // Longest delay from the top of time wraps the deadline.
    send_item(MODE_START, 4'd15, 32'hFFFF_FFFF, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(MODE_START, 4'd0, 32'd3, 32'd2, 64'd1000);
    // Rearms at the top of time wrap below now; each fires only once per tick.
    send_item(MODE_TICK, 4'hA, 32'h5555_5555, 32'hAAAA_AAAA, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(MODE_TICK, 4'h5, 32'hAAAA_AAAA, 32'h5555_5555, 64'hFFFF_FFFF_FFFF_FFFF);

    // Random episodes: a few starts, then ticks on an advancing clock; some items are fully random.
    rand_items = 0;
    wall_ns = 64'd0;
    while (rand_items < RAND_ITEMS) begin
      no_idle = (rand_items >= 150 && rand_items < 230);
      if ($urandom_range(99) < 12) begin
        send_item(1'($urandom), 4'($urandom), $urandom, $urandom, {$urandom, $urandom});
        rand_items++;
      end else begin
        case ($urandom_range(3))
          0: wall_ns = 64'($urandom_range(1000000000, 0));
          1: wall_ns = {$urandom, $urandom};
          2: wall_ns = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(20000000, 0));
          default: ;
        endcase
        n_starts = $urandom_range(6, 1);
        repeat (n_starts) begin
          wall_ns += 64'($urandom_range(300000, 0));
          delay_ms  = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(8, 0));
          reload_ms = ($urandom_range(9) < 4) ? 32'd0 : 32'($urandom_range(8, 1));
          send_item(MODE_START, 4'($urandom), delay_ms, reload_ms, wall_ns);
          rand_items++;
        end
        n_ticks = $urandom_range(6, 1);
        repeat (n_ticks) begin
          // Whole-millisecond steps land exactly on deadlines now and then.
          if ($urandom_range(1) == 1) begin
            wall_ns += 64'($urandom_range(4, 0)) * 64'd1000000;
          end else begin
            wall_ns += 64'($urandom_range(3000000, 0));
          end
          send_item(MODE_TICK, 4'($urandom), $urandom, $urandom, wall_ns);
          rand_items++;
        end
      end
    end
    no_idle = 1'b0;
    s_tvalid <= 1'b0;
    @(posedge clk);

    // Drain, then watch a while for stray results.
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Ran %0d start and %0d tick transfers; %0d timer expiries were checked.",
             start_count, tick_count, expiry_count);
    $display("Covered equal-time deadlines, id tie-breaks, rearms and 64-bit time wrap.");
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
design/ptq_pkg.sv
design/ptq_datapath.sv
design/ptq_ctrl.sv
design/periodic_timer_queue.sv
design/ptq_checker.sv
sim/timer_expiry_checker.sv
sim/testbench.sv
